// ===== sv/pixel_color_balance_defines.svh =====
// Assertion macros for the pixel colour balance block.
// Included by modules that carry concurrent checks; relies on clk and rst_n in scope.
`ifndef PIXEL_COLOR_BALANCE_DEFINES_SVH
`define PIXEL_COLOR_BALANCE_DEFINES_SVH

`ifndef SYNTH
// check sampled on clk, masked while reset is asserted
`define PCB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pixel_color_balance check failed");
// check sampled on clk, also active during reset
`define PCB_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pixel_color_balance reset check failed");
`else
`define PCB_ASSERT(lbl, prop)
`define PCB_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== sv/pcb_pkg.sv =====
// Shared types, constants and helper functions for the pixel colour balance block.
// No dependencies; imported by every module of the block.
package pcb_pkg;

  localparam int NSTAGE   = 8;      // register stages from input to output
  localparam int CH_MAX   = 255;
  localparam int SAT_DEN  = 20;
  // x/3 = (x*683)>>11, exact for x < 2048
  localparam int DIV3_MUL = 683;
  localparam int DIV3_SH  = 11;
  // x/5 = (x*52429)>>18, exact for x < 2^18
  localparam int DIV5_MUL = 52429;
  localparam int DIV5_SH  = 18;

  typedef enum logic [2:0] {
    REG_LIGHT = 3'd0,
    REG_SAT   = 3'd1,
    REG_RED   = 3'd2,
    REG_GREEN = 3'd3,
    REG_BLUE  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [7:0] light;
    logic signed [7:0] sat;
    logic signed [9:0] off_r;
    logic signed [9:0] off_g;
    logic signed [9:0] off_b;
  } pcb_cfg_t;

  typedef struct packed {
    logic [NSTAGE-1:0] en;
  } pcb_en_t;

  // (v*3)/4, truncating toward zero
  function automatic logic signed [7:0] three_quarters(input logic signed [7:0] v);
    logic signed [9:0] x3;
    logic signed [9:0] q;
    x3 = {{2{v[7]}}, v} + {v[7], v, 1'b0};
    if (x3[9]) begin
      q = (x3 + 10'sd3) >>> 2;
    end else begin
      q = x3 >>> 2;
    end
    return q[7:0];
  endfunction

  // v/2, truncating toward zero
  function automatic logic signed [7:0] half_tz(input logic signed [7:0] v);
    logic signed [7:0] h;
    if (v[7]) begin
      h = (v + 8'sd1) >>> 1;
    end else begin
      h = v >>> 1;
    end
    return h;
  endfunction

endpackage

// ===== sv/pixel_color_balance.sv =====
// Pixel colour balance: lightness, saturation and RGB balance on packed RGBA words.
// Pipeline: 8 register stages between the input handshake and out_tvalid.
// Throughput: one word per cycle; a stalled output holds only the stages behind it.
// Reset (rst_n low, synchronous): pipeline emptied, all five settings cleared to 0.
// Depends on pcb_pkg, pcb_cfg, pcb_ctrl, pcb_blend and pcb_bal.
module pixel_color_balance
  import pcb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pixel_in [31:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_out [31:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  pcb_cfg_t    cfg;
  pcb_en_t     ctl;
  logic [7:0]  alpha;
  logic [12:0] mag [3];
  logic        neg [3];

  pcb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  pcb_blend u_blend (
    .clk   (clk),
    .ctl   (ctl),
    .cfg   (cfg),
    .pix   (in_tdata),
    .alpha (alpha),
    .mag   (mag),
    .neg   (neg)
  );

  pcb_bal u_bal (
    .clk     (clk),
    .ctl     (ctl),
    .cfg     (cfg),
    .alpha   (alpha),
    .mag     (mag),
    .neg     (neg),
    .pix_out (out_tdata)
  );

endmodule

// ===== sv/pcb_cfg.sv =====
// Configuration registers and derived per-channel balance offsets.
// Depends on pcb_pkg and the assertion macros header.
`include "pixel_color_balance_defines.svh"

module pcb_cfg
  import pcb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output pcb_cfg_t   cfg
);

  logic signed [7:0] light_r, sat_r, red_r, green_r, blue_r;
  logic signed [7:0] kr, kg, kb, hr, hg, hb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r <= '0;
      sat_r   <= '0;
      red_r   <= '0;
      green_r <= '0;
      blue_r  <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_LIGHT: light_r <= cfg_data;
        REG_SAT:   sat_r   <= cfg_data;
        REG_RED:   red_r   <= cfg_data;
        REG_GREEN: green_r <= cfg_data;
        REG_BLUE:  blue_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    kr = three_quarters(red_r);
    kg = three_quarters(green_r);
    kb = three_quarters(blue_r);
    hr = half_tz(kr);
    hg = half_tz(kg);
    hb = half_tz(kb);
    cfg.light = light_r;
    cfg.sat   = sat_r;
    // own channel up by k, the other two down by k/2
    cfg.off_r = {{2{kr[7]}}, kr} - {{2{hg[7]}}, hg} - {{2{hb[7]}}, hb};
    cfg.off_g = {{2{kg[7]}}, kg} - {{2{hr[7]}}, hr} - {{2{hb[7]}}, hb};
    cfg.off_b = {{2{kb[7]}}, kb} - {{2{hr[7]}}, hr} - {{2{hg[7]}}, hg};
  end

  `PCB_ASSERT(a_sat_write, (cfg_valid && cfg_index == REG_SAT) |=> (sat_r == $past(cfg_data)))
  `PCB_ASSERT(a_light_hold, (!cfg_valid) |=> $stable(light_r))

endmodule

// ===== sv/pcb_ctrl.sv =====
// Pipeline valid tracking and per-stage load enables with backpressure.
// Depends on pcb_pkg and the assertion macros header.
`include "pixel_color_balance_defines.svh"

module pcb_ctrl
  import pcb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output pcb_en_t ctl
);

  logic [NSTAGE-1:0] valid_r, valid_nxt;
  logic [NSTAGE-1:0] rdy;
  logic              acc_in, acc_out;

  // a stage may load when empty or when its word moves on
  always_comb begin
    rdy[NSTAGE-1] = !valid_r[NSTAGE-1] || out_tready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      rdy[i] = !valid_r[i] || rdy[i+1];
    end
    valid_nxt[0] = rdy[0] ? in_tvalid : valid_r[0];
    for (int i = 1; i < NSTAGE; i++) begin
      valid_nxt[i] = rdy[i] ? valid_r[i-1] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ctl.en     = rdy;
  assign in_tready  = rdy[0];
  assign out_tvalid = valid_r[NSTAGE-1];
  assign acc_in     = in_tvalid && rdy[0];
  assign acc_out    = valid_r[NSTAGE-1] && out_tready;

  `PCB_ASSERT(a_fill, (acc_in && !acc_out) |=> ($countones(valid_r) == $countones($past(valid_r)) + 1))
  `PCB_ASSERT(a_drain, (!acc_in && acc_out) |=> ($countones(valid_r) + 1 == $countones($past(valid_r))))
  `PCB_ASSERT_RST(a_reset_empty, (!rst_n) |=> (valid_r == '0))

endmodule

// ===== sv/pcb_blend.sv =====
// Stages 1-5: lightness offset, grey mean and saturation blend with /20.
// Depends on pcb_pkg; output is magnitude and sign of each blended channel.
module pcb_blend
  import pcb_pkg::*;
(
  input  logic        clk,
  input  pcb_en_t     ctl,
  input  pcb_cfg_t    cfg,
  input  logic [31:0] pix,
  output logic [7:0]  alpha,
  output logic [12:0] mag [3],
  output logic        neg [3]
);

  // stage 1
  logic [7:0]         a1_r;
  logic signed [9:0]  c1_r [3];
  logic signed [9:0]  c1_nxt [3];
  logic signed [11:0] sum1_r, sum1_nxt;
  // stage 2
  logic [7:0]         a2_r;
  logic signed [9:0]  c2_r [3];
  logic signed [9:0]  grey2_r, grey2_nxt;
  logic [10:0]        smag;
  logic [20:0]        gprod;
  // stage 3
  logic [7:0]         a3_r;
  logic signed [8:0]  wgt;
  logic signed [18:0] pc3_r [3];
  logic signed [18:0] pc3_nxt [3];
  logic signed [17:0] pg3_r, pg3_nxt;
  // stage 4
  logic [7:0]         a4_r;
  logic signed [18:0] t4 [3];
  logic [16:0]        mag4_r [3];
  logic [16:0]        mag4_nxt [3];
  logic               neg4_r [3];
  // stage 5
  logic [7:0]         a5_r;
  logic [31:0]        qprod [3];
  logic [12:0]        q5_r [3];
  logic [12:0]        q5_nxt [3];
  logic               neg5_r [3];

  always_comb begin
    c1_nxt[0] = {2'b00, pix[23:16]} + {{2{cfg.light[7]}}, cfg.light};
    c1_nxt[1] = {2'b00, pix[15:8]}  + {{2{cfg.light[7]}}, cfg.light};
    c1_nxt[2] = {2'b00, pix[7:0]}   + {{2{cfg.light[7]}}, cfg.light};
    sum1_nxt  = 12'(c1_nxt[0]) + 12'(c1_nxt[1]) + 12'(c1_nxt[2]);
  end

  // grey = sum/3 toward zero, via magnitude
  always_comb begin
    smag      = sum1_r[11] ? 11'(-sum1_r) : sum1_r[10:0];
    gprod     = 21'(smag) * 21'(DIV3_MUL);
    grey2_nxt = sum1_r[11] ? -$signed({1'b0, gprod[DIV3_SH+8:DIV3_SH]})
                           : $signed({1'b0, gprod[DIV3_SH+8:DIV3_SH]});
  end

  always_comb begin
    wgt     = 9'(SAT_DEN) - 9'(cfg.sat);
    pg3_nxt = 18'(grey2_r) * 18'(cfg.sat);
    for (int i = 0; i < 3; i++) begin
      pc3_nxt[i] = 19'(c2_r[i]) * 19'(wgt);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t4[i]       = pc3_r[i] + 19'(pg3_r);
      mag4_nxt[i] = t4[i][18] ? 17'(-t4[i]) : t4[i][16:0];
    end
  end

  // /20 as >>2 then /5
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qprod[i]  = 32'(mag4_r[i][16:2]) * 32'(DIV5_MUL);
      q5_nxt[i] = qprod[i][DIV5_SH+12:DIV5_SH];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      a1_r   <= pix[31:24];
      c1_r   <= c1_nxt;
      sum1_r <= sum1_nxt;
    end
    if (ctl.en[1]) begin
      a2_r    <= a1_r;
      c2_r    <= c1_r;
      grey2_r <= grey2_nxt;
    end
    if (ctl.en[2]) begin
      a3_r  <= a2_r;
      pc3_r <= pc3_nxt;
      pg3_r <= pg3_nxt;
    end
    if (ctl.en[3]) begin
      a4_r   <= a3_r;
      mag4_r <= mag4_nxt;
      for (int i = 0; i < 3; i++) begin
        neg4_r[i] <= t4[i][18];
      end
    end
    if (ctl.en[4]) begin
      a5_r   <= a4_r;
      q5_r   <= q5_nxt;
      neg5_r <= neg4_r;
    end
  end

  assign alpha = a5_r;
  assign mag   = q5_r;
  assign neg   = neg5_r;

endmodule

// ===== sv/pcb_bal.sv =====
// Stages 6-8: balance offsets, clamp at zero, overflow spill and final clamp.
// Depends on pcb_pkg; the last stage is the output register.
module pcb_bal
  import pcb_pkg::*;
(
  input  logic        clk,
  input  pcb_en_t     ctl,
  input  pcb_cfg_t    cfg,
  input  logic [7:0]  alpha,
  input  logic [12:0] mag [3],
  input  logic        neg [3],
  output logic [31:0] pix_out
);

  logic signed [9:0]  off [3];
  logic signed [13:0] sv [3];
  logic signed [13:0] v6 [3];
  logic [7:0]         a6_r, a7_r;
  logic [12:0]        c6_r [3];
  logic [12:0]        c6_nxt [3];
  logic [13:0]        c7_r [3];
  logic [13:0]        c7_nxt [3];
  logic [11:0]        hr;
  logic [14:0]        r_a, g_a, b_a, hg, hb;
  logic [7:0]         r_o, g_o, b_o;
  logic [31:0]        out_r;

  assign off[0] = cfg.off_r;
  assign off[1] = cfg.off_g;
  assign off[2] = cfg.off_b;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sv[i]     = neg[i] ? -$signed({1'b0, mag[i]}) : $signed({1'b0, mag[i]});
      v6[i]     = sv[i] + 14'(off[i]);
      c6_nxt[i] = v6[i][13] ? '0 : v6[i][12:0];
    end
  end

  // red spills first
  always_comb begin
    hr        = '0;
    c7_nxt[0] = 14'(c6_r[0]);
    if (c6_r[0] > 13'(CH_MAX)) begin
      hr        = 12'((c6_r[0] - 13'(CH_MAX)) >> 1);
      c7_nxt[0] = 14'(CH_MAX);
    end
    c7_nxt[1] = 14'(c6_r[1]) + 14'(hr);
    c7_nxt[2] = 14'(c6_r[2]) + 14'(hr);
  end

  // then green, then blue, then the final clamp
  always_comb begin
    r_a = 15'(c7_r[0]);
    g_a = 15'(c7_r[1]);
    b_a = 15'(c7_r[2]);
    hg  = '0;
    hb  = '0;
    if (g_a > 15'(CH_MAX)) begin
      hg  = (g_a - 15'(CH_MAX)) >> 1;
      r_a = r_a + hg;
      b_a = b_a + hg;
      g_a = 15'(CH_MAX);
    end
    if (b_a > 15'(CH_MAX)) begin
      hb  = (b_a - 15'(CH_MAX)) >> 1;
      r_a = r_a + hb;
      g_a = g_a + hb;
      b_a = 15'(CH_MAX);
    end
    r_o = (r_a > 15'(CH_MAX)) ? 8'(CH_MAX) : r_a[7:0];
    g_o = (g_a > 15'(CH_MAX)) ? 8'(CH_MAX) : g_a[7:0];
    b_o = (b_a > 15'(CH_MAX)) ? 8'(CH_MAX) : b_a[7:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      a6_r <= alpha;
      c6_r <= c6_nxt;
    end
    if (ctl.en[6]) begin
      a7_r <= a6_r;
      c7_r <= c7_nxt;
    end
    if (ctl.en[7]) begin
      out_r <= {a7_r, r_o, g_o, b_o};
    end
  end

  assign pix_out = out_r;

endmodule
